/* rtl/core/crc8ldt_pkg.sv */
// Shared types and constants for the CRC-8 long-division tracer.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps

package crc8ldt_pkg;

   localparam int DEF_MAX_MSG_BYTES = 2048;
   localparam int BYTE_BITS         = 8;
   localparam int WIN_BITS          = 9;
   localparam int STEP_BITS         = 14;
   localparam int STEP_FIELD_MAX    = 16383;
   localparam int LEFT_BITS         = 5;     // holds up to 16 pending steps
   localparam int RSP_DATA_BITS     = 48;

   localparam logic [WIN_BITS-1:0] POLY_RESET = 9'h107;

   typedef enum logic {
      ST_IDLE,
      ST_BUSY
   } ctrl_state_type;

   typedef struct packed {
      logic load;   // take the input item into the datapath
      logic step;   // run one division step into the output register
   } dp_cmd_type;

   typedef struct packed {
      logic started;     // first byte of the message already loaded
      logic final_step;  // one step left for the current item
      logic out_free;    // output register can take a new result
   } dp_status_type;

endpackage

/* rtl/core/crc8ldt_controller.sv */
// Sequencer for the CRC-8 tracer: accepts items and issues division steps.
// Depends on crc8ldt_pkg.
`timescale 1ns / 1ps

module crc8ldt_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic                       req_eom,
   input  crc8ldt_pkg::dp_status_type status,
   output crc8ldt_pkg::dp_cmd_type    cmd
);

   crc8ldt_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crc8ldt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         crc8ldt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               // a first byte that does not end the message only loads
               if (status.started || req_eom) begin
                  state_in = crc8ldt_pkg::ST_BUSY;
               end
            end
         end
         crc8ldt_pkg::ST_BUSY: begin
            if (status.out_free) begin
               cmd.step = 1'b1;
               if (status.final_step) begin
                  state_in = crc8ldt_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = crc8ldt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/crc8ldt_datapath.sv */
// Datapath of the CRC-8 tracer: remainder, bit shifter, step counter,
// generator register and the result output register. Depends on crc8ldt_pkg.
`timescale 1ns / 1ps

module crc8ldt_datapath #(
   parameter int MAX_MSG_BYTES = crc8ldt_pkg::DEF_MAX_MSG_BYTES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [crc8ldt_pkg::WIN_BITS-1:0]      csr_wr_data,
   input  logic [crc8ldt_pkg::BYTE_BITS-1:0]     req_data_byte,
   input  logic                                  req_eom,
   input  crc8ldt_pkg::dp_cmd_type               cmd,
   output crc8ldt_pkg::dp_status_type            status,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [crc8ldt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tuser
);

   localparam int StepRaw    = MAX_MSG_BYTES * crc8ldt_pkg::BYTE_BITS - 1;
   localparam int StepCapInt = (StepRaw < crc8ldt_pkg::STEP_FIELD_MAX) ?
                               StepRaw : crc8ldt_pkg::STEP_FIELD_MAX;
   localparam logic [crc8ldt_pkg::STEP_BITS-1:0] StepCap =
      crc8ldt_pkg::STEP_BITS'(StepCapInt);

   localparam logic [crc8ldt_pkg::LEFT_BITS-1:0] StepsByte =
      crc8ldt_pkg::LEFT_BITS'(crc8ldt_pkg::BYTE_BITS);
   localparam logic [crc8ldt_pkg::LEFT_BITS-1:0] StepsBoth =
      crc8ldt_pkg::LEFT_BITS'(2 * crc8ldt_pkg::BYTE_BITS);

   logic [crc8ldt_pkg::WIN_BITS-1:0]  poly_ff, poly_in;
   logic [crc8ldt_pkg::BYTE_BITS-1:0] rem_ff, rem_in;
   logic [crc8ldt_pkg::BYTE_BITS-1:0] bits_ff, bits_in;
   logic [crc8ldt_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic [crc8ldt_pkg::LEFT_BITS-1:0] left_ff, left_in;
   logic                              started_ff, started_in;
   logic                              eom_ff, eom_in;
   logic                              valid_ff, valid_in;

   // result register
   logic [crc8ldt_pkg::STEP_BITS-1:0] o_step_ff, o_step_in;
   logic [crc8ldt_pkg::WIN_BITS-1:0]  o_before_ff, o_before_in;
   logic                              o_xor_ff, o_xor_in;
   logic [crc8ldt_pkg::WIN_BITS-1:0]  o_after_ff, o_after_in;
   logic                              o_last_ff, o_last_in;
   logic                              o_crcv_ff, o_crcv_in;
   logic [crc8ldt_pkg::BYTE_BITS-1:0] o_crc_ff, o_crc_in;

   logic [crc8ldt_pkg::WIN_BITS-1:0]  win;
   logic [crc8ldt_pkg::WIN_BITS-1:0]  after;
   logic                              final_step;
   logic                              crc_step;

   assign win        = {rem_ff, bits_ff[crc8ldt_pkg::BYTE_BITS-1]};
   assign after      = win[crc8ldt_pkg::WIN_BITS-1] ? (win ^ poly_ff) : win;
   assign final_step = (left_ff == crc8ldt_pkg::LEFT_BITS'(1));
   assign crc_step   = final_step && eom_ff;

   assign status.started    = started_ff;
   assign status.final_step = final_step;
   assign status.out_free   = !valid_ff || rsp_tready;

   always_comb begin
      poly_in     = csr_wr_en ? csr_wr_data : poly_ff;
      rem_in      = rem_ff;
      bits_in     = bits_ff;
      step_in     = step_ff;
      left_in     = left_ff;
      started_in  = started_ff;
      eom_in      = eom_ff;
      valid_in    = valid_ff && !rsp_tready;
      o_step_in   = o_step_ff;
      o_before_in = o_before_ff;
      o_xor_in    = o_xor_ff;
      o_after_in  = o_after_ff;
      o_last_in   = o_last_ff;
      o_crcv_in   = o_crcv_ff;
      o_crc_in    = o_crc_ff;

      if (cmd.load) begin
         eom_in = req_eom;
         if (started_ff) begin
            bits_in = req_data_byte;
            left_in = req_eom ? StepsBoth : StepsByte;
         end else begin
            // first byte goes straight into the remainder
            rem_in     = req_data_byte;
            started_in = 1'b1;
            bits_in    = '0;
            left_in    = req_eom ? StepsByte : '0;
         end
      end else if (cmd.step) begin
         bits_in     = {bits_ff[crc8ldt_pkg::BYTE_BITS-2:0], 1'b0};
         left_in     = left_ff - crc8ldt_pkg::LEFT_BITS'(1);
         valid_in    = 1'b1;
         o_step_in   = step_ff;
         o_before_in = win;
         o_xor_in    = win[crc8ldt_pkg::WIN_BITS-1];
         o_after_in  = after;
         o_last_in   = final_step;
         o_crcv_in   = crc_step;
         o_crc_in    = crc_step ? after[crc8ldt_pkg::BYTE_BITS-1:0] : '0;
         if (crc_step) begin
            rem_in     = '0;
            started_in = 1'b0;
            step_in    = '0;
         end else begin
            rem_in = after[crc8ldt_pkg::BYTE_BITS-1:0];
            if (step_ff < StepCap) begin
               step_in = step_ff + crc8ldt_pkg::STEP_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff    <= crc8ldt_pkg::POLY_RESET;
         rem_ff     <= '0;
         step_ff    <= '0;
         left_ff    <= '0;
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         poly_ff    <= poly_in;
         rem_ff     <= rem_in;
         step_ff    <= step_in;
         left_ff    <= left_in;
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff     <= bits_in;
      eom_ff      <= eom_in;
      o_step_ff   <= o_step_in;
      o_before_ff <= o_before_in;
      o_xor_ff    <= o_xor_in;
      o_after_ff  <= o_after_in;
      o_last_ff   <= o_last_in;
      o_crcv_ff   <= o_crcv_in;
      o_crc_ff    <= o_crc_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tuser  = o_crcv_ff;
   assign rsp_tdata  = {7'b0, o_crc_ff, o_after_ff, o_xor_ff, o_before_ff, o_step_ff};

endmodule

/* rtl/core/crc8_long_division_tracer_unit.sv */
// CRC-8 long-division tracer, MSB first, zero init, no reflection.
// Each accepted byte on req_ becomes up to 16 step trace items on rsp_.
// Input item: a message byte, tlast marks the last byte of the message.
// The first byte of a message only loads the remainder; it gives no item unless it is also the last byte.
// Each later byte gives 8 items, one per division step; the last byte
// adds 8 more steps over appended zeros, the final one carrying the CRC.
// csr_wr_en/csr_wr_data write the 9-bit generator (reset 0x107); write
// only while the block is idle.
// Timing: req_tready is high only while no step is pending. A step runs
// per cycle through the single shared XOR/shift unit into the output
// register while that register is free to take it. The load registers
// the byte and each step then registers one result; the next byte is
// accepted once the byte's last step has run. A byte that gives no item
// needs no step.
// A stalled rsp_tready holds the output register and pauses the steps;
// the next byte is taken while the final item of a byte still waits.
// Reset (synchronous) drops pending work and restores the generator.
// Depends on crc8ldt_pkg, crc8ldt_controller and crc8ldt_datapath.
`timescale 1ns / 1ps

module crc8_long_division_tracer_unit #(
   parameter int MAX_MSG_BYTES = crc8ldt_pkg::DEF_MAX_MSG_BYTES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [crc8ldt_pkg::WIN_BITS-1:0]      csr_wr_data,   // generator_poly
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [crc8ldt_pkg::BYTE_BITS-1:0]     req_tdata,     // [7:0] data_byte
   input  logic                                  req_tlast,     // end_of_message
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [13:0] step_index, [22:14] window_before, [23] did_xor,
   // [32:24] window_after, [40:33] crc_value, [47:41] zero
   output logic [crc8ldt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                                  rsp_tlast,     // run_last
   output logic                                  rsp_tuser      // [0] crc_valid
);

   crc8ldt_pkg::dp_cmd_type    cmd;
   crc8ldt_pkg::dp_status_type status;

   crc8ldt_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_eom    (req_tlast),
      .status     (status),
      .cmd        (cmd)
   );

   crc8ldt_datapath #(
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_data_byte (req_tdata),
      .req_eom       (req_tlast),
      .cmd           (cmd),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

/* rtl/core/crc8ldt_checker.sv */
// Port-level checks for the CRC-8 tracer, bound to the top level.
// Depends on crc8ldt_pkg and crc8_long_division_tracer_unit.
`timescale 1ns / 1ps

module crc8ldt_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [crc8ldt_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input logic                                  rsp_tlast,
   input logic                                  rsp_tuser
);

   // stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("rsp item changed while stalled");

   // the CRC step is always the final item of its byte
   a_crc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("crc_valid without run_last");

   // crc_value reads zero except on the CRC step
   a_crc_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[40:33] == 8'd0)
      else $error("crc_value set outside CRC step");

   // XOR decision follows the window's leading bit
   a_xor_msb: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23] == rsp_tdata[22])
      else $error("did_xor disagrees with window MSB");

endmodule

bind crc8_long_division_tracer_unit crc8ldt_checker u_checker (.*);

/* sim/tb.sv */
// Self-checking bench for crc8_long_division_tracer_unit: stream driver, trace checker.
// Depends on crc8ldt_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb;

   localparam int STEP_CAP =
      (crc8ldt_pkg::DEF_MAX_MSG_BYTES * 8 - 1 < crc8ldt_pkg::STEP_FIELD_MAX) ?
      crc8ldt_pkg::DEF_MAX_MSG_BYTES * 8 - 1 : crc8ldt_pkg::STEP_FIELD_MAX;
   localparam int QUIET_LIMIT  = 2000;  // cycles with no item moving on either side
   localparam int CSR_PAD      = 20;    // settle time before a generator write
   localparam int TAIL_CYCLES  = 40;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [crc8ldt_pkg::STEP_BITS-1:0] step_index;
      logic [crc8ldt_pkg::WIN_BITS-1:0]  win_before;
      logic                              did_xor;
      logic [crc8ldt_pkg::WIN_BITS-1:0]  win_after;
      logic                              run_last;
      logic                              crc_valid;
      logic [crc8ldt_pkg::BYTE_BITS-1:0] crc_value;
   } step_rec_type;

   class crc_trace_board;
      logic [crc8ldt_pkg::WIN_BITS-1:0]  gen_poly;
      logic [crc8ldt_pkg::BYTE_BITS-1:0] remainder;
      bit                                started;
      logic [crc8ldt_pkg::STEP_BITS-1:0] step_count;
      step_rec_type                      expected_steps[$];
      int                                bytes_seen;
      int                                steps_checked;
      int                                mismatches;

      function new();
         gen_poly      = crc8ldt_pkg::POLY_RESET;
         remainder     = '0;
         started       = 0;
         step_count    = '0;
         bytes_seen    = 0;
         steps_checked = 0;
         mismatches    = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
         end
      endfunction

      // one shift/xor step of the long division
      function step_rec_type divide_bit(logic b);
         step_rec_type s;
         s = '0;
         s.step_index = step_count;
         s.win_before = {remainder, b};
         s.did_xor    = s.win_before[crc8ldt_pkg::WIN_BITS-1];
         s.win_after  = s.did_xor ? (s.win_before ^ gen_poly) : s.win_before;
         remainder    = s.win_after[crc8ldt_pkg::BYTE_BITS-1:0];
         if (step_count < STEP_CAP) begin
            step_count++;
         end
         return s;
      endfunction

      function void take_byte(logic [crc8ldt_pkg::BYTE_BITS-1:0] d, logic last);
         logic [15:0]  feed;
         step_rec_type s;
         int           n;
         feed = '0;
         n    = 0;
         bytes_seen++;
         if (!started) begin
            remainder = d;
            started   = 1;
         end else begin
            feed = {d, 8'h00};
            n    = 8;
         end
         // appended zeros sit below the data bits in feed
         if (last) begin
            n += 8;
         end
         for (int k = 0; k < n; k++) begin
            s = divide_bit(feed[15-k]);
            s.run_last = (k == n - 1);
            if (last && k == n - 1) begin
               s.crc_valid = 1'b1;
               s.crc_value = s.win_after[crc8ldt_pkg::BYTE_BITS-1:0];
            end
            expected_steps = {expected_steps, s};
         end
         if (last) begin
            remainder  = '0;
            started    = 0;
            step_count = '0;
         end
      endfunction

      function void check_step(logic [crc8ldt_pkg::RSP_DATA_BITS-1:0] tdata, logic tlast,
                               logic tuser);
         step_rec_type a;
         step_rec_type e;
         a.step_index = tdata[13:0];
         a.win_before = tdata[22:14];
         a.did_xor    = tdata[23];
         a.win_after  = tdata[32:24];
         a.crc_value  = tdata[40:33];
         a.run_last   = tlast;
         a.crc_valid  = tuser;
         if (expected_steps.size() == 0) begin
            flag($sformatf("step item with none expected: idx=%0d win=%h", a.step_index,
                           a.win_before));
            return;
         end
         e = expected_steps.pop_front();
         steps_checked++;
         if (a !== e) begin
            flag($sformatf({"exp idx=%0d win=%h xor=%b after=%h last=%b crcv=%b crc=%h / ",
                            "got idx=%0d win=%h xor=%b after=%h last=%b crcv=%b crc=%h"},
                           e.step_index, e.win_before, e.did_xor, e.win_after, e.run_last,
                           e.crc_valid, e.crc_value, a.step_index, a.win_before, a.did_xor,
                           a.win_after, a.run_last, a.crc_valid, a.crc_value));
         end
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  csr_wr_en;
   logic [crc8ldt_pkg::WIN_BITS-1:0]      csr_wr_data;
   logic                                  req_tvalid;
   logic                                  req_tready;
   logic [crc8ldt_pkg::BYTE_BITS-1:0]     req_tdata;
   logic                                  req_tlast;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready;
   logic [crc8ldt_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                                  rsp_tlast;
   logic                                  rsp_tuser;

   crc_trace_board                    trace_sb;
   logic [crc8ldt_pkg::BYTE_BITS-1:0] msg_bytes[$];
   bit                                src_idle;
   bit                                sink_idle;
   int                                hold_request;
   int                                quiet_cycles;
   int                                gen_writes;

   crc8_long_division_tracer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // accept monitor, result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            trace_sb.take_byte(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            trace_sb.check_step(rsp_tdata, rsp_tlast, rsp_tuser);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("crc8_long_division_tracer_unit verification failed");
            $finish;
         end
      end
   end

   // result side: per-item stall, plus an optional long hold-off
   initial begin
      int gap;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = sink_idle ? $urandom_range(0, 9) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready) && hold_request == 0);
      end
   end

   task automatic send_byte(logic [crc8ldt_pkg::BYTE_BITS-1:0] d, logic last);
      int gap;
      gap = src_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic send_msg();
      for (int i = 0; i < msg_bytes.size(); i++) begin
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      end
   endtask

   task automatic random_msg(int len);
      msg_bytes.delete();
      repeat (len) begin
         msg_bytes = {msg_bytes, crc8ldt_pkg::BYTE_BITS'($urandom_range(0, 255))};
      end
      send_msg();
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (trace_sb.pending() != 0);
   endtask

   task automatic write_generator(logic [crc8ldt_pkg::WIN_BITS-1:0] v);
      drain();
      repeat (CSR_PAD) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trace_sb.gen_poly = v;
      gen_writes++;
   endtask

   initial begin
      int phase_items;
      int len;
      logic [crc8ldt_pkg::WIN_BITS-1:0] poly;
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      src_idle     = 1;
      sink_idle    = 1;
      hold_request = 0;
      quiet_cycles = 0;
      gen_writes   = 0;
      trace_sb     = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset generator, single-byte messages, byte extremes, check string
      msg_bytes = {8'h00};                           send_msg();
      msg_bytes = {8'hFF};                           send_msg();
      msg_bytes = {8'hA5, 8'h5A};                    send_msg();
      msg_bytes = {8'h00, 8'hFF, 8'h80};             send_msg();
      msg_bytes = {8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
      send_msg();
      // zero generator: windows pass through even when the top bit is set; then an all-ones generator
      write_generator(9'h000);
      msg_bytes = {8'hFF};                           send_msg();
      write_generator(9'h1FF);
      msg_bytes = {8'hFF, 8'h7F};                    send_msg();
      // generator without its top bit
      write_generator(9'h0FF);
      msg_bytes = {8'hC3, 8'h81, 8'hFF};             send_msg();

      // random phases, each with its own generator and idling mix
      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       poly = 9'h100;
            1:       poly = 9'h1FF;
            2:       poly = 9'h000;
            5:       poly = crc8ldt_pkg::POLY_RESET;
            default: poly = crc8ldt_pkg::WIN_BITS'($urandom_range(0, 511));
         endcase
         write_generator(poly);
         src_idle  = (p % 4 == 0) || (p % 4 == 2);
         sink_idle = (p % 4 == 0) || (p % 4 == 3);
         // receiver stalls hard while the sender streams without gaps
         if (p == 1) begin
            hold_request = HOLD_CYCLES;
         end
         phase_items = 0;
         while (phase_items < 24) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
            random_msg(len);
            phase_items += len;
            if ($urandom_range(0, 5) == 0) begin
               drain();
            end
         end
      end

      // a short message once everything has settled
      drain();
      src_idle  = 1;
      sink_idle = 1;
      random_msg(3);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (trace_sb.pending() != 0) begin
         trace_sb.flag($sformatf("%0d step items never arrived", trace_sb.pending()));
      end
      $display("coverage: %0d bytes sent, %0d step items checked, %0d generator writes",
               trace_sb.bytes_seen, trace_sb.steps_checked, gen_writes);
      $display("includes a %0d-cycle output stall against a gapless sender",
               HOLD_CYCLES);
      if (trace_sb.mismatches == 0) begin
         $display("crc8_long_division_tracer_unit verification clean");
      end else begin
         $display("%0d mismatches", trace_sb.mismatches);
         $display("crc8_long_division_tracer_unit verification failed");
      end
      $finish;
   end

endmodule
